@@ rtl/clock_field_setting_editor_macros.svh @@
// Assertion macros for the clock field setting editor.
`ifndef CLOCK_FIELD_SETTING_EDITOR_MACROS_SVH
`define CLOCK_FIELD_SETTING_EDITOR_MACROS_SVH

`ifndef SYNTH
`define CFSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CFSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CFSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/cfse_pkg.sv @@
// Field codes, limits and the month length table for the clock field editor.
`timescale 1ns / 1ps
package cfse_pkg;

    localparam logic       REQ_STEP  = 1'b0;
    localparam logic       REQ_DIGIT = 1'b1;

    localparam logic [2:0] FIELD_SEC   = 3'd0;
    localparam logic [2:0] FIELD_MIN   = 3'd1;
    localparam logic [2:0] FIELD_HOUR  = 3'd2;
    localparam logic [2:0] FIELD_WDAY  = 3'd3;
    localparam logic [2:0] FIELD_DATE  = 3'd4;
    localparam logic [2:0] FIELD_MONTH = 3'd5;
    localparam logic [2:0] FIELD_YEAR  = 3'd6;
    localparam logic [2:0] FIELD_NONE  = 3'd7;   // no field; requests on it write nothing

    localparam logic [1:0] SLOT_SEC  = 2'd0;
    localparam logic [1:0] SLOT_MIN  = 2'd1;
    localparam logic [1:0] SLOT_HOUR = 2'd2;

    localparam logic [7:0] ALL_ONES   = 8'hff;
    localparam logic [7:0] MIN_MAX    = 8'd59;
    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] WDAY_MAX   = 8'd7;
    localparam logic [7:0] MONTH_MAX  = 8'd12;
    localparam logic [7:0] YEAR_MAX   = 8'd99;
    localparam logic [7:0] DAYS_LONG  = 8'd31;
    localparam logic [7:0] DAYS_FEB   = 8'd29;
    localparam logic [7:0] DAYS_SHORT = 8'd30;

    typedef logic [7:0] slot_val_t;

    function automatic slot_val_t month_days(input logic [3:0] m);
        slot_val_t d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAYS_LONG;
            4'd2:                                       d = DAYS_FEB;
            default:                                    d = DAYS_SHORT;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/clock_field_setting_editor.sv @@
// Top level of the clock and calendar field editor.
// A taken word moves from the input register to the result register when that stage advances.
// Throughput: one word per cycle; a held result lets one more word in, then tready drops.
// Reset (rst_n low, asynchronous): display slots and remembered month clear to zero,
// both pipeline stages empty.
// Every request yields exactly one result word; tuser flags whether a slot was written.
`timescale 1ns / 1ps
`include "clock_field_setting_editor_macros.svh"
module clock_field_setting_editor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] field, [3] step_up, [7:4] digit
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] slot, [9:2] slot_value, [10] blank_tens, pad
    output logic        m_axis_tuser    // [0] written
);

    // input register
    logic       in_valid_reg;
    logic       in_type_reg;
    logic [2:0] in_field_reg;
    logic       in_up_reg;
    logic [3:0] in_digit_reg;

    // result register
    logic       out_valid_reg;
    logic       out_written_reg;
    logic [1:0] out_slot_reg;
    logic [7:0] out_value_reg;
    logic       out_blank_reg;

    // editor state
    cfse_pkg::slot_val_t slots_reg [3];
    logic [3:0]          month_reg;

    logic advance;
    logic fire;

    // result stage moves when empty or drained; input stage refills behind it
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_type_reg  <= s_axis_tuser;
            in_field_reg <= s_axis_tdata[2:0];
            in_up_reg    <= s_axis_tdata[3];
            in_digit_reg <= s_axis_tdata[7:4];
        end
    end

    // ---------------------------------------------------------------
    // edit logic
    // ---------------------------------------------------------------
    logic [1:0]          slot_sel;
    cfse_pkg::slot_val_t cur;
    cfse_pkg::slot_val_t stepped;
    cfse_pkg::slot_val_t entered;
    cfse_pkg::slot_val_t result;
    cfse_pkg::slot_val_t mdays;
    logic                wr;
    logic                blank;
    logic                month_wr;
    logic                cand_ok;
    logic [7:0]          cand;

    always_comb
    begin
        case (in_field_reg)
            cfse_pkg::FIELD_SEC, cfse_pkg::FIELD_WDAY:
                slot_sel = cfse_pkg::SLOT_SEC;
            cfse_pkg::FIELD_MIN, cfse_pkg::FIELD_MONTH, cfse_pkg::FIELD_YEAR:
                slot_sel = cfse_pkg::SLOT_MIN;
            default:
                slot_sel = cfse_pkg::SLOT_HOUR;
        endcase
    end

    always_comb
    begin
        case (slot_sel)
            cfse_pkg::SLOT_SEC: cur = slots_reg[0];
            cfse_pkg::SLOT_MIN: cur = slots_reg[1];
            default:            cur = slots_reg[2];
        endcase
    end

    assign mdays = cfse_pkg::month_days(month_reg);

    // step: +/-1 mod 256, wrap only on the exact overflow value
    always_comb
    begin
        stepped = in_up_reg ? cur + 8'd1 : cur - 8'd1;
        case (in_field_reg)
            cfse_pkg::FIELD_SEC, cfse_pkg::FIELD_MIN:
            begin
                if (in_up_reg && stepped == cfse_pkg::MIN_MAX + 8'd1) stepped = 8'd0;
                if (!in_up_reg && stepped == cfse_pkg::ALL_ONES)      stepped = cfse_pkg::MIN_MAX;
            end
            cfse_pkg::FIELD_HOUR:
            begin
                if (in_up_reg && stepped == cfse_pkg::HOUR_MAX + 8'd1) stepped = 8'd0;
                if (!in_up_reg && stepped == cfse_pkg::ALL_ONES)       stepped = cfse_pkg::HOUR_MAX;
            end
            cfse_pkg::FIELD_WDAY:
            begin
                if (in_up_reg && stepped == cfse_pkg::WDAY_MAX + 8'd1) stepped = 8'd1;
                if (!in_up_reg && stepped == 8'd0)                     stepped = cfse_pkg::WDAY_MAX;
            end
            cfse_pkg::FIELD_DATE:
            begin
                if (in_up_reg && stepped == mdays + 8'd1) stepped = 8'd1;
                if (!in_up_reg && stepped == 8'd0)        stepped = mdays;
            end
            cfse_pkg::FIELD_MONTH:
            begin
                if (in_up_reg && stepped == cfse_pkg::MONTH_MAX + 8'd1) stepped = 8'd1;
                if (!in_up_reg && stepped == 8'd0)                      stepped = cfse_pkg::MONTH_MAX;
            end
            default:
            begin
                if (in_up_reg && stepped == cfse_pkg::YEAR_MAX + 8'd1) stepped = 8'd0;
                if (!in_up_reg && stepped == cfse_pkg::ALL_ONES)       stepped = cfse_pkg::YEAR_MAX;
            end
        endcase
    end

    // digit entry: value*10 + digit if the value is one digit and the pair fits, else the digit
    assign cand = {cur[4:0], 3'b000} + {2'b00, cur[4:0], 1'b0} + {4'b0000, in_digit_reg};

    always_comb
    begin
        case (in_field_reg)
            cfse_pkg::FIELD_MIN:   cand_ok = cand <= cfse_pkg::MIN_MAX;
            cfse_pkg::FIELD_HOUR:  cand_ok = cand <= cfse_pkg::HOUR_MAX;
            cfse_pkg::FIELD_DATE:  cand_ok = cand >= 8'd1 && cand <= cfse_pkg::DAYS_LONG;
            cfse_pkg::FIELD_MONTH: cand_ok = cand >= 8'd1 && cand <= cfse_pkg::MONTH_MAX;
            cfse_pkg::FIELD_YEAR:  cand_ok = cand <= cfse_pkg::YEAR_MAX;
            default:               cand_ok = 1'b0;
        endcase
        entered = (cur < 8'd10 && cand_ok) ? cand : {4'b0000, in_digit_reg};
    end

    always_comb
    begin
        wr       = 1'b1;
        blank    = 1'b0;
        month_wr = 1'b0;
        result   = stepped;
        if (in_field_reg == cfse_pkg::FIELD_NONE)
        begin
            wr = 1'b0;           // unused field code
        end
        else if (in_type_reg == cfse_pkg::REQ_STEP)
        begin
            if (in_field_reg == cfse_pkg::FIELD_MONTH)
            begin
                month_wr = 1'b1;
                blank    = stepped < 8'd10;
            end
        end
        else
        begin
            result = entered;
            if (in_field_reg inside {cfse_pkg::FIELD_SEC, cfse_pkg::FIELD_WDAY})
            begin
                wr = 1'b0;
            end
            else if (entered == 8'd0 &&
                     (in_field_reg inside {cfse_pkg::FIELD_MONTH, cfse_pkg::FIELD_DATE}))
            begin
                wr = 1'b0;       // zero month or date is ignored
            end
            else
            begin
                blank = (in_field_reg inside {cfse_pkg::FIELD_MONTH, cfse_pkg::FIELD_MIN}) &&
                        entered < 8'd10;
            end
        end
    end

    // ---------------------------------------------------------------
    // state and result registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg[0] <= '0;
            slots_reg[1] <= '0;
            slots_reg[2] <= '0;
            month_reg    <= '0;
        end
        else if (fire)
        begin
            if (wr)
            begin
                case (slot_sel)
                    cfse_pkg::SLOT_SEC: slots_reg[0] <= result;
                    cfse_pkg::SLOT_MIN: slots_reg[1] <= result;
                    default:            slots_reg[2] <= result;
                endcase
            end
            if (month_wr)
            begin
                month_reg <= (stepped >= 8'd1 && stepped <= cfse_pkg::MONTH_MAX) ?
                             stepped[3:0] : 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_written_reg <= wr;
            out_slot_reg    <= wr ? slot_sel : 2'd0;
            out_value_reg   <= wr ? result : 8'd0;
            out_blank_reg   <= wr && blank;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_written_reg;
    assign m_axis_tdata  = {5'b00000, out_blank_reg, out_value_reg, out_slot_reg};

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `CFSE_ASSERT_IMP(a_idle_result_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0)
    `CFSE_ASSERT_IMP(a_slot_legal, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `CFSE_ASSERT_IMP(a_month_legal, clk, rst_n, 1'b1, {4'd0, month_reg} <= cfse_pkg::MONTH_MAX)
    `CFSE_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `CFSE_ASSERT_NEXT(a_accept_loads, clk, rst_n, s_axis_tvalid && s_axis_tready, in_valid_reg)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the clock and calendar field editor.
`timescale 1ns / 1ps
module testbench;

    localparam logic       STEP_DOWN  = 1'b0;
    localparam logic       STEP_UP    = 1'b1;
    localparam logic       TYPED      = 1'b1;  // row carries its own expected word
    localparam logic       PREDICTED  = 1'b0;  // row is checked against the predictor

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_WORDS   = 700;
    localparam int LONG_HOLD      = 80;    // receiver hold-off, far deeper than the pipe
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 10;    // catches stray words after the last one

    // One result word, in the order the fields are compared and reported.
    typedef struct packed {
        logic       written;
        logic [1:0] slot;
        logic [7:0] value;
        logic       blank;
    } edit_result_t;

    // One request word plus an optional hand-written expectation.
    typedef struct packed {
        logic         req;
        logic [2:0]   fld;
        logic         up;
        logic [3:0]   dig;
        logic         typed;
        edit_result_t exp;
    } edit_cmd_t;

    localparam edit_result_t NOTHING_WRITTEN = '0;

    // Directed opening: wraps of the second, minute and hour fields from the
    // reset state, the ignored requests (digit on sec or weekday, field code
    // 7), a value out of range stepped without wrap, date wrap under a
    // remembered month, zero month or date by digit, and a digit above 9.
    localparam edit_cmd_t DIRECTED [28] = '{
        // Slots start at zero, so the down/up pairs land on the wrap values.
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_SEC, STEP_DOWN, 4'd0, TYPED,
          '{1'b1, cfse_pkg::SLOT_SEC, cfse_pkg::MIN_MAX, 1'b0}},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_SEC, STEP_UP, 4'd0, TYPED,
          '{1'b1, cfse_pkg::SLOT_SEC, 8'd0, 1'b0}},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MIN, STEP_DOWN, 4'd0, TYPED,
          '{1'b1, cfse_pkg::SLOT_MIN, cfse_pkg::MIN_MAX, 1'b0}},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MIN, STEP_UP, 4'd0, TYPED,
          '{1'b1, cfse_pkg::SLOT_MIN, 8'd0, 1'b0}},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_HOUR, STEP_DOWN, 4'd0, TYPED,
          '{1'b1, cfse_pkg::SLOT_HOUR, cfse_pkg::HOUR_MAX, 1'b0}},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_HOUR, STEP_UP, 4'd0, TYPED,
          '{1'b1, cfse_pkg::SLOT_HOUR, 8'd0, 1'b0}},
        // Requests that must write nothing.
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_SEC,   STEP_UP,   4'd9,  TYPED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_WDAY,  STEP_DOWN, 4'd15, TYPED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP,  cfse_pkg::FIELD_NONE,  STEP_UP,   4'd0,  TYPED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_NONE,  STEP_UP,   4'd0,  TYPED, NOTHING_WRITTEN},
        // Weekday 0 -> 1 -> 7 -> 1.
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_WDAY, STEP_UP,   4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_WDAY, STEP_DOWN, 4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_WDAY, STEP_UP,   4'd0, PREDICTED, NOTHING_WRITTEN},
        // Month 0 -> 255 (no wrap) -> 0 -> 1 -> 12.
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MONTH, STEP_DOWN, 4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MONTH, STEP_UP,   4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MONTH, STEP_UP,   4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MONTH, STEP_DOWN, 4'd0, PREDICTED, NOTHING_WRITTEN},
        // Date under month 12: 0 -> 1 -> 31 -> 1.
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_DATE, STEP_UP,   4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_DATE, STEP_DOWN, 4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_STEP, cfse_pkg::FIELD_DATE, STEP_UP,   4'd0, PREDICTED, NOTHING_WRITTEN},
        // Digit entry: zero month, fresh digit, second digit, digit above 9.
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_MONTH, STEP_UP, 4'd0, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_MONTH, STEP_UP, 4'd1, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_MONTH, STEP_UP, 4'd2, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_MONTH, STEP_UP, 4'd15, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_YEAR,  STEP_UP, 4'd9, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_MIN,   STEP_UP, 4'd5, PREDICTED, NOTHING_WRITTEN},
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_HOUR,  STEP_UP, 4'd3, PREDICTED, NOTHING_WRITTEN},
        // Date slot holds 13 here, so a 0 replaces it and is dropped.
        '{cfse_pkg::REQ_DIGIT, cfse_pkg::FIELD_DATE,  STEP_UP, 4'd0, PREDICTED, NOTHING_WRITTEN}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Predictor state: the three display slots and the last stepped month.
    logic [7:0]   shown_slots [3] = '{8'd0, 8'd0, 8'd0};
    logic [3:0]   stepped_month   = 4'd0;

    edit_result_t pending_words [$];
    int           words_sent      = 0;
    int           mismatches      = 0;
    int           tx_idle_pct     = 27;
    int           rx_idle_pct     = 50;
    logic         long_hold_armed = 1'b0;
    logic         long_hold_done  = 1'b0;
    int           hold_left       = 0;
    int           quiet_cycles    = 0;

    clock_field_setting_editor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // Days in the remembered month; anything outside 1..12 counts as 30.
    function automatic logic [7:0] days_in(input logic [3:0] m);
        logic [7:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = cfse_pkg::DAYS_LONG;
            4'd2:                                       d = cfse_pkg::DAYS_FEB;
            default:                                    d = cfse_pkg::DAYS_SHORT;
        endcase
        return d;
    endfunction

    // Applies one edit request to the predictor state and returns the word
    // the block should send back for it.
    function automatic edit_result_t apply_edit(input logic req, input logic [2:0] fld,
                                                input logic up, input logic [3:0] dig);
        edit_result_t res;
        logic [1:0]   s;
        logic [7:0]   v;
        logic [7:0]   mx;
        int           two_digit;
        logic         fits;
        logic         wr;
        logic         blank;
        res   = NOTHING_WRITTEN;
        wr    = 1'b1;
        blank = 1'b0;
        if (fld > cfse_pkg::FIELD_YEAR)
            return res;
        case (fld)
            cfse_pkg::FIELD_SEC, cfse_pkg::FIELD_WDAY:
                s = cfse_pkg::SLOT_SEC;
            cfse_pkg::FIELD_MIN, cfse_pkg::FIELD_MONTH, cfse_pkg::FIELD_YEAR:
                s = cfse_pkg::SLOT_MIN;
            default:
                s = cfse_pkg::SLOT_HOUR;
        endcase
        v = shown_slots[s];
        if (req == cfse_pkg::REQ_STEP)
        begin
            // Plain 8-bit step; wrap only on the exact overflow value.
            v = up ? v + 8'd1 : v - 8'd1;
            case (fld)
                cfse_pkg::FIELD_SEC, cfse_pkg::FIELD_MIN:
                begin
                    if (up && v == cfse_pkg::MIN_MAX + 8'd1) v = 8'd0;
                    if (!up && v == cfse_pkg::ALL_ONES)      v = cfse_pkg::MIN_MAX;
                end
                cfse_pkg::FIELD_HOUR:
                begin
                    if (up && v == cfse_pkg::HOUR_MAX + 8'd1) v = 8'd0;
                    if (!up && v == cfse_pkg::ALL_ONES)       v = cfse_pkg::HOUR_MAX;
                end
                cfse_pkg::FIELD_WDAY:
                begin
                    if (up && v == cfse_pkg::WDAY_MAX + 8'd1) v = 8'd1;
                    if (!up && v == 8'd0)                     v = cfse_pkg::WDAY_MAX;
                end
                cfse_pkg::FIELD_DATE:
                begin
                    mx = days_in(stepped_month);
                    if (up && v == mx + 8'd1) v = 8'd1;
                    if (!up && v == 8'd0)     v = mx;
                end
                cfse_pkg::FIELD_MONTH:
                begin
                    if (up && v == cfse_pkg::MONTH_MAX + 8'd1) v = 8'd1;
                    if (!up && v == 8'd0)                      v = cfse_pkg::MONTH_MAX;
                    stepped_month = (v >= 8'd1 && v <= cfse_pkg::MONTH_MAX) ? v[3:0] : 4'd0;
                    blank = (v < 8'd10);
                end
                default:
                begin
                    if (up && v == cfse_pkg::YEAR_MAX + 8'd1) v = 8'd0;
                    if (!up && v == cfse_pkg::ALL_ONES)       v = cfse_pkg::YEAR_MAX;
                end
            endcase
        end
        else if (fld == cfse_pkg::FIELD_SEC || fld == cfse_pkg::FIELD_WDAY)
        begin
            wr = 1'b0;
        end
        else
        begin
            // Second digit if the slot holds one digit and the pair is legal.
            two_digit = int'(v) * 10 + int'(dig);
            case (fld)
                cfse_pkg::FIELD_MIN:
                    fits = (two_digit <= int'(cfse_pkg::MIN_MAX));
                cfse_pkg::FIELD_HOUR:
                    fits = (two_digit <= int'(cfse_pkg::HOUR_MAX));
                cfse_pkg::FIELD_DATE:
                    fits = (two_digit >= 1 && two_digit <= int'(cfse_pkg::DAYS_LONG));
                cfse_pkg::FIELD_MONTH:
                    fits = (two_digit >= 1 && two_digit <= int'(cfse_pkg::MONTH_MAX));
                default:
                    fits = (two_digit <= int'(cfse_pkg::YEAR_MAX));
            endcase
            if (v < 8'd10 && fits)
                v = 8'(two_digit);
            else
                v = 8'(dig);
            if (v == 8'd0 && (fld == cfse_pkg::FIELD_MONTH || fld == cfse_pkg::FIELD_DATE))
                wr = 1'b0;
            else if ((fld == cfse_pkg::FIELD_MONTH || fld == cfse_pkg::FIELD_MIN) && v < 8'd10)
                blank = 1'b1;
        end
        if (wr)
        begin
            shown_slots[s] = v;
            res = '{1'b1, s, v, blank};
        end
        return res;
    endfunction

    function automatic logic [3:0] pick_digit();
        // Mostly real key digits, sometimes the codes above 9.
        if ($urandom_range(0, 99) < 12)
            return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    function automatic edit_cmd_t plain_cmd(input logic req, input logic [2:0] fld,
                                            input logic up, input logic [3:0] dig);
        edit_cmd_t c;
        c     = '0;
        c.req = req;
        c.fld = fld;
        c.up  = up;
        c.dig = dig;
        c.typed = PREDICTED;
        return c;
    endfunction

    // Offers one request word, possibly after random idle cycles. Called and
    // returning at a falling edge; valid is left high so back-to-back words
    // never see it drop.
    task automatic send_edit(input edit_cmd_t cmd);
        edit_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd.req;
        s_axis_tdata  = {cmd.dig, cmd.up, cmd.fld};
        do @(posedge clk); while (!s_axis_tready);
        // Accepted at this edge: update the predictor in acceptance order.
        predicted = apply_edit(cmd.req, cmd.fld, cmd.up, cmd.dig);
        pending_words.push_back(cmd.typed ? cmd.exp : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // Random traffic. Most of it is shaped: runs of steps on one field in one
    // direction reach the wrap points, digit pairs build two-digit values,
    // and a month step followed by a date run exercises every month length.
    task automatic random_phase(input int goal);
        int         stop_at;
        int         mode;
        int         len;
        logic [2:0] fld;
        logic       up;
        stop_at = words_sent + goal;
        while (words_sent < stop_at)
        begin
            mode = $urandom_range(0, 9);
            fld  = 3'($urandom_range(cfse_pkg::FIELD_SEC, cfse_pkg::FIELD_YEAR));
            up   = 1'($urandom_range(0, 1));
            if (mode < 4)
            begin
                if ($urandom_range(0, 19) == 0)
                    fld = cfse_pkg::FIELD_NONE;
                send_edit(plain_cmd(1'($urandom_range(0, 1)), fld, up, pick_digit()));
            end
            else if (mode < 7)
            begin
                len = $urandom_range(2, 35);
                repeat (len) send_edit(plain_cmd(cfse_pkg::REQ_STEP, fld, up, pick_digit()));
            end
            else if (mode < 9)
            begin
                repeat (2) send_edit(plain_cmd(cfse_pkg::REQ_DIGIT, fld, up, pick_digit()));
            end
            else
            begin
                send_edit(plain_cmd(cfse_pkg::REQ_STEP, cfse_pkg::FIELD_MONTH, up, pick_digit()));
                len = $urandom_range(1, 33);
                up  = 1'($urandom_range(0, 1));
                repeat (len)
                    send_edit(plain_cmd(cfse_pkg::REQ_STEP, cfse_pkg::FIELD_DATE, up,
                                        pick_digit()));
            end
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off once armed so the
    // pipe fills and the input side has to stall.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left     = hold_left - 1;
        end
        else if (long_hold_armed && !long_hold_done)
        begin
            m_axis_tready  = 1'b0;
            hold_left      = LONG_HOLD - 1;
            long_hold_done = 1'b1;
        end
        else
        begin
            m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic void note_mismatch(input string what, input edit_result_t want,
                                          input edit_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected written=%0b slot=%0d value=%0d blank=%0b, %s%0b %s%0d %s%0d %s%0b",
                     $realtime, what, want.written, want.slot, want.value, want.blank,
                     "got written=", got.written, "slot=", got.slot,
                     "value=", got.value, "blank=", got.blank);
    endfunction

    // Result checker: every word leaving the block is matched in order.
    always @(posedge clk)
    begin : check_words
        edit_result_t got;
        edit_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[10]};
            if (pending_words.size() == 0)
            begin
                note_mismatch("unexpected word", NOTHING_WRITTEN, got);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    note_mismatch("word mismatch", want, got);
            end
        end
    end

    // Watchdog: a stretch with no word moving on either side means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles 27%, receiver 50%.
        foreach (DIRECTED[i])
            send_edit(DIRECTED[i]);
        random_phase(RANDOM_WORDS / 3);

        // Roles swapped.
        tx_idle_pct = 50;
        rx_idle_pct = 27;
        random_phase(RANDOM_WORDS / 3);

        // Full rate both ways, opening with the long receiver hold-off.
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        long_hold_armed = 1'b1;
        random_phase(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

        s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cfse_pkg.sv
rtl/clock_field_setting_editor.sv
verif/testbench.sv
